// ----- src/lss_pkg.sv -----
`default_nettype none

package lss_pkg;

  // Default sizes of the stack.
  localparam int unsigned DEPTH_DEF      = 16;
  localparam int unsigned DATA_WIDTH_DEF = 32;

  // Fixed field widths of the stream items.
  localparam int unsigned CMD_W     = 2;
  localparam int unsigned OPERAND_W = 32;
  localparam int unsigned OUTCOME_W = 2;
  localparam int unsigned ITEM_W    = 32;
  localparam int unsigned POS_W     = 5;

  localparam int unsigned S_TDATA_W = 32;
  localparam int unsigned M_TDATA_W = 48;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_PUSH   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_POP    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;

  // Outcome codes.
  localparam logic [OUTCOME_W-1:0] OUT_OK    = 2'd0;
  localparam logic [OUTCOME_W-1:0] OUT_EMPTY = 2'd1;
  localparam logic [OUTCOME_W-1:0] OUT_FULL  = 2'd2;
  localparam logic [OUTCOME_W-1:0] OUT_MISS  = 2'd3;

  // Control broadcast to every cell of the chain.
  typedef struct packed {
    logic push;   // take the word of the neighbor above
    logic pop;    // take the word of the neighbor below
    logic load;   // capture the compare result
    logic shift;  // take the match bit of the neighbor below
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ----- src/lss_cell.sv -----
`default_nettype none

module lss_cell #(
  parameter int unsigned DATA_WIDTH = lss_pkg::DATA_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  lss_pkg::cell_ctrl_t   ctrl_i,
  input  logic [DATA_WIDTH-1:0] word_above_i,
  input  logic [DATA_WIDTH-1:0] word_below_i,
  input  logic [DATA_WIDTH-1:0] key_i,
  input  logic                  match_below_i,
  output logic [DATA_WIDTH-1:0] word_o,
  output logic                  match_o
);
  import lss_pkg::*;

  logic [DATA_WIDTH-1:0] word_q, word_d;
  logic                  match_q, match_d;

  always_comb begin
    word_d = word_q;
    if (ctrl_i.push) begin
      word_d = word_above_i;
    end else if (ctrl_i.pop) begin
      word_d = word_below_i;
    end
  end

  always_comb begin
    match_d = match_q;
    if (ctrl_i.load) begin
      match_d = (word_q == key_i);
    end else if (ctrl_i.shift) begin
      match_d = match_below_i;
    end
  end

  // The stored word is payload and needs no reset.
  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
    end else begin
      match_q <= match_d;
    end
  end

  assign word_o  = word_q;
  assign match_o = match_q;

endmodule

`default_nettype wire

// ----- src/lifo_stack_with_search.sv -----
`default_nettype none

// LIFO stack of DEPTH signed words built as a chain of cells, cell 0 holding
// the top. Each input item is one command (tuser: push, pop or search) with
// its operand in tdata, and each gives exactly one result item. Push and pop
// shift the whole chain by one cell. A search compares every cell with the
// operand at once and then shifts the match bits toward the top one cell per
// cycle until the first hit reaches cell 0 or every filled cell has been
// scanned; no new item is taken meanwhile. A search on an empty stack answers
// without a scan. The result sits in an output register. The next item is
// taken at once when no result waits, or in the cycle in which the waiting
// result is taken, as long as no search is still scanning.
module lifo_stack_with_search #(
  parameter int unsigned DEPTH      = lss_pkg::DEPTH_DEF,
  parameter int unsigned DATA_WIDTH = lss_pkg::DATA_WIDTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // [31:0] operand
  input  logic [lss_pkg::S_TDATA_W-1:0]     s_axis_tdata_i,
  // [1:0] command
  input  logic [lss_pkg::CMD_W-1:0]         s_axis_tuser_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // [31:0] item_out, [36:32] found_at, [41:37] fill_level, [47:42] zero
  output logic [lss_pkg::M_TDATA_W-1:0]     m_axis_tdata_o,
  // [1:0] outcome
  output logic [lss_pkg::OUTCOME_W-1:0]     m_axis_tuser_o
);
  import lss_pkg::*;

  localparam int unsigned FILL_W = $clog2(DEPTH + 1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic                  state_q, state_d;
  logic [FILL_W-1:0]     fill_q, fill_d;
  logic [FILL_W-1:0]     cnt_q, cnt_d;
  logic [FILL_W-1:0]     cnt_inc;
  cell_ctrl_t            ctrl;

  logic [DATA_WIDTH-1:0] word_w  [DEPTH];
  logic                  match_w [DEPTH];
  logic [DATA_WIDTH-1:0] key;

  logic                  accept;
  logic                  out_free;
  logic                  full;
  logic                  empty;

  logic                  res_set;
  logic [OUTCOME_W-1:0]  res_outcome;
  logic [ITEM_W-1:0]     res_item;
  logic [POS_W-1:0]      res_pos;

  logic                  out_valid_q, out_valid_d;
  logic [OUTCOME_W-1:0]  outcome_q;
  logic [ITEM_W-1:0]     item_q;
  logic [POS_W-1:0]      pos_q;
  logic [POS_W-1:0]      level_q;

  assign key      = DATA_WIDTH'($signed(s_axis_tdata_i[OPERAND_W-1:0]));
  assign out_free = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == ST_IDLE) && out_free;
  assign accept   = s_axis_tvalid_i && s_axis_tready_o;
  assign full     = (fill_q == FILL_W'(DEPTH));
  assign empty    = (fill_q == '0);
  assign cnt_inc  = cnt_q + FILL_W'(1);

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] above;
    logic [DATA_WIDTH-1:0] below;
    logic                  mbelow;

    if (i == 0) begin : g_top
      assign above = key;
    end else begin : g_mid
      assign above = word_w[i-1];
    end

    if (i == DEPTH - 1) begin : g_bottom
      assign below  = word_w[i];
      assign mbelow = 1'b0;
    end else begin : g_inner
      assign below  = word_w[i+1];
      assign mbelow = match_w[i+1];
    end

    lss_cell #(
      .DATA_WIDTH (DATA_WIDTH)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl),
      .word_above_i  (above),
      .word_below_i  (below),
      .key_i         (key),
      .match_below_i (mbelow),
      .word_o        (word_w[i]),
      .match_o       (match_w[i])
    );
  end

  always_comb begin
    ctrl        = '0;
    state_d     = state_q;
    fill_d      = fill_q;
    cnt_d       = cnt_q;
    res_set     = 1'b0;
    res_outcome = OUT_OK;
    res_item    = '0;
    res_pos     = '0;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (s_axis_tuser_i)
            CMD_PUSH: begin
              res_set = 1'b1;
              if (full) begin
                res_outcome = OUT_FULL;
              end else begin
                ctrl.push = 1'b1;
                fill_d    = fill_q + FILL_W'(1);
              end
            end
            CMD_POP: begin
              res_set = 1'b1;
              if (empty) begin
                res_outcome = OUT_EMPTY;
              end else begin
                ctrl.pop = 1'b1;
                fill_d   = fill_q - FILL_W'(1);
                res_item = ITEM_W'(word_w[0]);
              end
            end
            CMD_SEARCH: begin
              if (empty) begin
                res_set     = 1'b1;
                res_outcome = OUT_EMPTY;
              end else begin
                ctrl.load = 1'b1;
                cnt_d     = '0;
                state_d   = ST_SCAN;
              end
            end
            default: begin
              res_set = 1'b1;
            end
          endcase
        end
      end
      ST_SCAN: begin
        // Cell 0 now holds the match bit of stack position cnt_q.
        if (match_w[0]) begin
          res_set = 1'b1;
          res_pos = POS_W'(cnt_inc);
          state_d = ST_IDLE;
        end else if (cnt_inc == fill_q) begin
          res_set     = 1'b1;
          res_outcome = OUT_MISS;
          state_d     = ST_IDLE;
        end else begin
          ctrl.shift = 1'b1;
          cnt_d      = cnt_inc;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_set) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_set) begin
      outcome_q <= res_outcome;
      item_q    <= res_item;
      pos_q     <= res_pos;
      level_q   <= POS_W'(fill_d);
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = outcome_q;
  assign m_axis_tdata_o  = {(M_TDATA_W - ITEM_W - 2 * POS_W)'(0), level_q, pos_q, item_q};

endmodule

`default_nettype wire

// ----- src/lss_checker.sv -----
`default_nettype none

module lss_checker #(
  parameter int unsigned DEPTH = lss_pkg::DEPTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tready_o,
  input  logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  input  logic [lss_pkg::M_TDATA_W-1:0] m_axis_tdata_o,
  input  logic [lss_pkg::OUTCOME_W-1:0] m_axis_tuser_o
);
  import lss_pkg::*;

  logic [ITEM_W-1:0] item;
  logic [POS_W-1:0]  pos;
  logic [POS_W-1:0]  level;

  assign item  = m_axis_tdata_o[31:0];
  assign pos   = m_axis_tdata_o[36:32];
  assign level = m_axis_tdata_o[41:37];

  // A result that is not taken stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result item dropped while stalled");

  // No item is taken while a stalled result occupies the output.
  a_in_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |-> !s_axis_tready_o)
    else $error("input ready while the output is stalled");

  // A hit position only comes with a successful search.
  a_pos_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (pos != '0) |-> (m_axis_tuser_o == OUT_OK) && (item == '0))
    else $error("hit position on a result that is not a search hit");

  // A reported full stack has every cell in use.
  a_full_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o == OUT_FULL) |-> (level == POS_W'(DEPTH)))
    else $error("full outcome with a fill level below the depth");

  // An empty outcome comes only from an empty stack.
  a_empty_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o == OUT_EMPTY) |-> (level == '0) && (pos == '0))
    else $error("empty outcome with stored entries");

endmodule

bind lifo_stack_with_search lss_checker #(.DEPTH(DEPTH)) u_lss_checker (.*);

`default_nettype wire
